// File: hdl/swmm_pkg.sv
// Package for the sliding window min/max block: sizes, sample and token types.
// No dependencies; used by the interfaces and by every module under hdl.
`default_nettype none

package swmm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 7;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [CFG_W-1:0]         t_cfg;

    // Running minimum and maximum that walks down the cell chain.
    typedef struct packed {
        logic    valid;
        t_sample lo;
        t_sample hi;
    } t_token;

    // Window size register value to index of the last cell covered.
    function automatic t_idx last_index(input t_cfg size);
        t_idx res;
        if (size == '0) begin
            res = '0;
        end else if (32'(size) > MAX_WINDOW) begin
            res = IDX_W'(MAX_WINDOW - 1);
        end else begin
            res = IDX_W'(size - t_cfg'(1));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/swmm_ifs.sv
// Valid/ready channel interfaces for samples, results and configuration.
// Depends on swmm_pkg.
`default_nettype none

interface swmm_in_if;
    logic              valid;
    logic              ready;
    swmm_pkg::t_sample sample;
    logic              start_of_sequence;

    modport source (output valid, output sample, output start_of_sequence, input ready);
    modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swmm_out_if;
    logic              valid;
    logic              ready;
    swmm_pkg::t_sample window_min;
    swmm_pkg::t_sample window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

interface swmm_cfg_if;
    logic           valid;
    logic           ready;
    swmm_pkg::t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/swmm_cell.sv
// One cell of the window chain: holds one sample of the shift line and folds it
// into the min/max token passing through. Depends on swmm_pkg.
`default_nettype none

module swmm_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_shift,
    input  swmm_pkg::t_sample i_data,
    output swmm_pkg::t_sample o_data,
    input  swmm_pkg::t_token  i_tok,
    output swmm_pkg::t_token  o_tok,
    input  wire               i_last,
    input  wire               i_out_free,
    output swmm_pkg::t_token  o_done
);
    import swmm_pkg::*;

    t_sample r_data;
    t_token  r_tok;
    t_token  n_tok;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    always_comb begin
        n_tok = r_tok;
        if (r_tok.valid) begin
            // last cell holds the token until the output register is free
            n_tok.valid = i_last && !i_out_free;
        end
        if (i_tok.valid) begin
            n_tok.valid = 1'b1;
            n_tok.lo    = (r_data < i_tok.lo) ? r_data : i_tok.lo;
            n_tok.hi    = (r_data > i_tok.hi) ? r_data : i_tok.hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.lo <= n_tok.lo;
        r_tok.hi <= n_tok.hi;
    end

    assign o_data = r_data;

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok.valid && !i_last;
    end

    // zeroed unless done, so the top can OR all cells together
    always_comb begin
        o_done.valid = r_tok.valid && i_last;
        o_done.lo    = o_done.valid ? r_tok.lo : '0;
        o_done.hi    = o_done.valid ? r_tok.hi : '0;
    end

endmodule

`default_nettype wire

// File: hdl/sliding_window_min_max.sv
// Top level of the sliding window min/max block: cell chain, fill tracking,
// launch and output registers. Depends on swmm_pkg, swmm_ifs and swmm_cell.
`default_nettype none

// Each accepted sample shifts into a chain of MAX_WINDOW cells, cell j holding
// the sample j transfers back. Once K samples (K = window size, 0 read as 1,
// above MAX_WINDOW read as MAX_WINDOW) have arrived since the last start flag,
// a min/max token walks from cell 0 down to cell K-1, one cell per cycle, and
// lands in the output register. An item with a result holds off further input
// transfers until its token has left the chain; an item with no result does
// not hold up the input. The output register lets the next sample be taken
// while a result waits; a finished token stalls in its cell only if the
// output register is still full. Window size writes are taken at any time
// and meant for when the block is idle.
module sliding_window_min_max (
    input  wire        i_clk,
    input  wire        i_rst_n,
    swmm_in_if.sink    i_in,
    swmm_out_if.source o_out,
    swmm_cfg_if.sink   i_cfg
);
    import swmm_pkg::*;

    t_idx   r_last_idx;
    t_cnt   r_fill;
    t_cnt   n_fill;
    t_token r_launch;
    logic   r_out_valid;
    t_sample r_min;
    t_sample r_max;

    t_sample data_chain [MAX_WINDOW+1];
    t_token  tok_chain  [MAX_WINDOW+1];
    t_token  done_tok   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] tok_busy;
    t_token  done_any;
    logic    in_xfer;
    logic    out_free;
    logic    busy;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= '0;
        end else if (i_cfg.valid) begin
            r_last_idx <= last_index(i_cfg.data);
        end
    end

    assign busy        = r_launch.valid || (|tok_busy);
    assign i_in.ready  = !busy;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        n_fill = i_in.start_of_sequence ? '0 : r_fill;
        if (32'(n_fill) < MAX_WINDOW) begin
            n_fill = n_fill + t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill         <= '0;
            r_launch.valid <= 1'b0;
        end else begin
            r_launch.valid <= in_xfer && (n_fill > {1'b0, r_last_idx});
            if (in_xfer) begin
                r_fill <= n_fill;
            end
        end
        if (in_xfer) begin
            r_launch.lo <= i_in.sample;
            r_launch.hi <= i_in.sample;
        end
    end

    assign data_chain[0] = i_in.sample;
    assign tok_chain[0]  = r_launch;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        swmm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (in_xfer),
            .i_data     (data_chain[g]),
            .o_data     (data_chain[g+1]),
            .i_tok      (tok_chain[g]),
            .o_tok      (tok_chain[g+1]),
            .i_last     (r_last_idx == IDX_W'(g)),
            .i_out_free (out_free),
            .o_done     (done_tok[g])
        );
        assign tok_busy[g] = tok_chain[g+1].valid || done_tok[g].valid;
    end

    always_comb begin
        done_any = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            done_any = done_any | done_tok[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= done_any.valid;
        end
        if (out_free && done_any.valid) begin
            r_min <= done_any.lo;
            r_max <= done_any.hi;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.window_min = r_min;
    assign o_out.window_max = r_max;

endmodule

`default_nettype wire
